// File: rtl/core/itmr_pkg.sv
// Shared types and constants of the interval timer with input ports.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package itmr_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  // Register selects inside the ports block
  localparam logic [1:0] SEL_PORT_A = 2'd0;
  localparam logic [1:0] SEL_DIR_A  = 2'd1;
  localparam logic [1:0] SEL_PORT_B = 2'd2;
  localparam logic [1:0] SEL_DIR_B  = 2'd3;

  // Address bit that selects the timer block, and flag encodings
  localparam int unsigned TIMER_BLOCK_BIT = 2;
  localparam int unsigned FLAG_UF_BIT     = 1;
  localparam logic [1:0]  FLAGS_BOTH      = 2'b11;
  localparam logic [1:0]  PRESCALE_RESET  = 2'd3;
  localparam logic [1:0]  PRESCALE_FAST   = 2'd0;
  localparam logic [7:0]  COUNT_WRAP      = 8'hFF;

  localparam int unsigned ACC_W = 11;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ITER,
    ST_DONE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture the input word
    logic exec;      // perform the read, write or accumulate
    logic step;      // consume one prescale period if elapsed
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_tick;   // captured item is a tick
    logic elapsed;   // accumulator holds at least one period
    logic out_free;  // output register can take a word this cycle
  } stat_t;

  // Prescale period in cycles for a prescale code
  function automatic logic [ACC_W-1:0] period_of(input logic [1:0] code);
    logic [ACC_W-1:0] p;
    case (code)
      2'd0:    p = ACC_W'(1);
      2'd1:    p = ACC_W'(8);
      2'd2:    p = ACC_W'(64);
      default: p = ACC_W'(1024);
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/itmr_ctrl.sv
// Sequencing state machine of the interval timer.
// Depends on itmr_pkg; drives the datapath through cmd_t and reads stat_t.
`timescale 1ns / 1ps
`default_nettype none

module itmr_ctrl
  import itmr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = stat_i.is_tick ? ST_ITER : ST_DONE;
      end
      ST_ITER: begin
        if (!stat_i.elapsed) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC: cmd_o.exec = 1'b1;
      ST_ITER: cmd_o.step = 1'b1;
      ST_DONE: cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/itmr_dp.sv
// Datapath of the interval timer: item capture, timer and port registers,
// output register. Depends on itmr_pkg; controlled by itmr_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module itmr_dp
  import itmr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       cmd_i,
  output stat_t           stat_o,
  input  wire logic [1:0] opcode_i,
  input  wire logic [2:0] reg_addr_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic [3:0] cycles_i,
  input  wire logic [7:0] port_a_pins_i,
  input  wire logic [7:0] port_b_pins_i,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      read_data_o,
  output logic            underflow_flag_o
);

  // Captured item
  logic [1:0] op_q;
  logic [2:0] addr_q;
  logic [7:0] wdata_q;
  logic [3:0] cyc_q;
  logic [7:0] pa_q;
  logic [7:0] pb_q;

  // Architectural state
  logic [7:0]       count_q, count_d;
  logic [1:0]       presc_q, presc_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [1:0]       flags_q, flags_d;
  logic [7:0]       dir_a_q, dir_a_d;
  logic [7:0]       dir_b_q, dir_b_d;
  logic [7:0]       rd_q, rd_d;

  // Output register
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_uf_q;

  logic [ACC_W-1:0] period;
  logic             elapsed;
  logic             timer_sel;

  assign period    = period_of(presc_q);
  assign elapsed   = (acc_q >= period);
  assign timer_sel = addr_q[TIMER_BLOCK_BIT];

  assign stat_o.is_tick  = (op_q == OP_TICK);
  assign stat_o.elapsed  = elapsed;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      addr_q  <= reg_addr_i;
      wdata_q <= write_data_i;
      cyc_q   <= cycles_i;
      pa_q    <= port_a_pins_i;
      pb_q    <= port_b_pins_i;
    end
  end

  // Execute the item and run the prescale loop
  always_comb begin
    count_d = count_q;
    presc_d = presc_q;
    acc_d   = acc_q;
    flags_d = flags_q;
    dir_a_d = dir_a_q;
    dir_b_d = dir_b_q;
    rd_d    = rd_q;
    if (cmd_i.exec) begin
      rd_d = '0;
      case (op_q)
        OP_READ: begin
          if (timer_sel) begin
            if (addr_q[0]) begin
              rd_d = {flags_q, 6'b0};
            end else begin
              rd_d = count_q;
              flags_d[FLAG_UF_BIT] = 1'b0;
            end
          end else begin
            unique case (addr_q[1:0])
              SEL_PORT_A: rd_d = pa_q;
              SEL_DIR_A:  rd_d = dir_a_q;
              SEL_PORT_B: rd_d = pb_q;
              SEL_DIR_B:  rd_d = dir_b_q;
              default:    rd_d = '0;
            endcase
          end
        end
        OP_WRITE: begin
          if (timer_sel) begin
            presc_d = addr_q[1:0];
            count_d = wdata_q;
            acc_d   = '0;
            flags_d = '0;
          end else if (addr_q[1:0] == SEL_DIR_A) begin
            dir_a_d = wdata_q;
          end else if (addr_q[1:0] == SEL_DIR_B) begin
            dir_b_d = wdata_q;
          end
        end
        OP_TICK: acc_d = acc_q + ACC_W'(cyc_q);
        default: ;
      endcase
    end else if (cmd_i.step && elapsed) begin
      // One prescale period has passed: count down, wrap on underflow
      acc_d = acc_q - period;
      if (count_q == '0) begin
        count_d = COUNT_WRAP;
        presc_d = PRESCALE_FAST;
        flags_d = FLAGS_BOTH;
      end else begin
        count_d = count_q - 8'd1;
      end
    end
  end

  // Hold the timer and port state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      presc_q <= PRESCALE_RESET;
      acc_q   <= '0;
      flags_q <= '0;
      dir_a_q <= '0;
      dir_b_q <= '0;
    end else begin
      count_q <= count_d;
      presc_q <= presc_d;
      acc_q   <= acc_d;
      flags_q <= flags_d;
      dir_a_q <= dir_a_d;
      dir_b_q <= dir_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rd_d;
  end

  // Output register: load a word, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= rd_q;
      out_uf_q   <= flags_q[FLAG_UF_BIT];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_data_q;
  assign underflow_flag_o = out_uf_q;

  // The accumulator never exceeds one period plus a full tick
  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q < period + ACC_W'(16))
    else $error("cycle accumulator out of range");

  // An underflow step switches to the fastest prescale and sets both flags
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && elapsed && count_q == '0) |=>
      (presc_q == PRESCALE_FAST && flags_q == FLAGS_BOTH && count_q == COUNT_WRAP))
    else $error("underflow did not wrap the timer");

  // A timer write restarts the accumulator and clears the flags
  a_timer_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && op_q == OP_WRITE && timer_sel) |=> (acc_q == '0 && flags_q == '0))
    else $error("timer write did not restart the timer");

  // A loaded result is presented on the next cycle
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("result word lost");

endmodule

`default_nettype wire

// File: rtl/core/interval_timer_io_ports.sv
// Top level of the interval timer with input ports.
// Depends on itmr_pkg, itmr_ctrl and itmr_dp.
//
// Interval timer with two input ports and their direction registers. Each
// input word is a bus read, a bus write or a tick of 0 to 15 elapsed cycles,
// and each gives exactly one result word with the read byte (zero for writes
// and ticks) and the underflow flag. A read or write passes through the
// execute and done states before its result word can be taken and the next
// word accepted; a tick also runs the prescale loop between them, which
// consumes one elapsed prescale period per cycle until it finds that no
// further period has elapsed. The next word is accepted once the previous
// result has been moved into the output register, even while that result
// still waits to be taken; a result that cannot move in holds the input off.
`timescale 1ns / 1ps
`default_nettype none

module interval_timer_io_ports
  import itmr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] reg_addr, [10:3] write_data, [14:11] cycles,
  // [22:15] port_a_pins, [30:23] port_b_pins, [31] zero
  input  wire logic [31:0] s_axis_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] read_data, [8] underflow_flag, [15:9] zero
  output logic [15:0]      m_axis_tdata
);

  cmd_t  cmd;
  stat_t stat;

  logic [7:0] read_data;
  logic       underflow_flag;

  itmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  itmr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .opcode_i         (s_axis_tuser),
    .reg_addr_i       (s_axis_tdata[2:0]),
    .write_data_i     (s_axis_tdata[10:3]),
    .cycles_i         (s_axis_tdata[14:11]),
    .port_a_pins_i    (s_axis_tdata[22:15]),
    .port_b_pins_i    (s_axis_tdata[30:23]),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .read_data_o      (read_data),
    .underflow_flag_o (underflow_flag)
  );

  // Pack the result word
  assign m_axis_tdata = {7'b0, underflow_flag, read_data};

endmodule

`default_nettype wire
